// File: rtl/core/vst_pkg.sv
// Package for the value set table: command and status codes, sizing constants
// and the control struct sent to each storage cell.
// It has no dependencies.
package vst_pkg;

  // Default sizing of the table.
  localparam int unsigned DefaultCapacity   = 16;
  localparam int unsigned DefaultValueWidth = 32;

  // Fixed field widths on the ports.
  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned InValWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 5;

  // Command codes. The unused code is handled as a query.
  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // Status codes reported with each result.
  typedef enum logic [StatusWidth-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic cmp_en;  // capture the compare result
    logic live;    // cell lies within the filled part of the table
    logic load;    // write the broadcast value into the cell
    logic shift;   // take the entry of the next cell
  } vst_cell_ctrl_t;

endpackage

// File: rtl/core/vst_cell.sv
// One storage cell of the value set table: an entry, its comparator and the
// shift path from the next cell.
// Depends on vst_pkg.
module vst_cell import vst_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vst_cell_ctrl_t         ctrl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] next_entry_i,
  output logic [VALUE_WIDTH-1:0] entry_o,
  output logic                   match_o
);

  logic [VALUE_WIDTH-1:0] entry_d, entry_q;
  logic                   match_d, match_q;

  // A cell only matches while it holds a live entry.
  assign match_d = ctrl_i.live && (entry_q == value_i);

  // Load has priority over shift; the two never occur together.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = value_i;
    end else if (ctrl_i.shift) begin
      entry_d = next_entry_i;
    end
  end

  // The entry itself needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // The compare flag is held until the next compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// File: rtl/core/vst_match_enc.sv
// Reduces the per-cell match flags of the value set table to a hit flag and
// the index of the matching cell. Depends on vst_pkg.
module vst_match_enc import vst_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity,
  localparam int unsigned IdxW    = $clog2(CAPACITY)
) (
  input  logic [CAPACITY-1:0] match_i,
  output logic                found_o,
  output logic [IdxW-1:0]     slot_o
);

  // Values are distinct, so at most one flag is set and an OR of the
  // gated indices gives the slot.
  always_comb begin
    slot_o = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (match_i[i]) begin
        slot_o = slot_o | IdxW'(i);
      end
    end
  end

  assign found_o = |match_i;

endmodule

// File: rtl/core/value_set_table_top.sv
// Value set table: a set of distinct values held in a compact row of cells.
// Channels: an input channel (command_i, value_i) and a result channel
// (found_o, status_o, count_o, empty_res_o), each with valid and ready.
// A command adds a value when absent and there is room, removes a value
// and closes the gap by shifting the later cells down one place, or only
// queries membership. Every transfer in gives exactly one result.
// Steps: after an input transfer the cells compare the value in the compare
// state and register their match flags; in the update state the table is
// updated and the result is registered once the output register is free.
// One item is processed at a time: the next input is not taken until the
// update step of the last item is done.
// The result sits in an output register; the next input is accepted while
// it waits. If the receiver stalls, a finished item is held before the
// update step until the output register is free, and input ready stays low.
// Reset empties the table at once: the count goes to zero and no cell
// content is cleared. The output channel is empty after reset.
// Depends on vst_pkg, vst_cell and vst_match_enc.
module value_set_table_top import vst_pkg::*; #(
  parameter int unsigned CAPACITY    = DefaultCapacity,
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CmdWidth-1:0]    command_i,
  input  logic [InValWidth-1:0]  value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o,
  output logic [StatusWidth-1:0] status_o,
  output logic [CountWidth-1:0]  count_o,
  output logic                   empty_res_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e                   state_d, state_q;
  logic [CmdWidth-1:0]      cmd_q;
  logic [VALUE_WIDTH-1:0]   val_q;
  logic [CntW-1:0]          count_d, count_q;
  logic                     out_valid_d, out_valid_q;
  logic                     found_q, empty_q;
  logic [StatusWidth-1:0]   status_d, status_q;
  logic [CountWidth-1:0]    count_out_q;

  logic                     in_fire, upd_fire;
  logic                     hit;
  logic [IdxW-1:0]          slot;
  logic                     do_add, do_remove;
  logic [CAPACITY-1:0]      match;
  logic [VALUE_WIDTH-1:0]   entry [CAPACITY];
  vst_cell_ctrl_t           ctrl  [CAPACITY];
  logic [InValWidth+VALUE_WIDTH-1:0] val_ext;
  logic [CntW+CountWidth-1:0]        count_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_fire   = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  // The value is taken in its low VALUE_WIDTH bits.
  assign val_ext = {{VALUE_WIDTH{1'b0}}, value_i};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= command_i;
      val_q <= val_ext[VALUE_WIDTH-1:0];
    end
  end

  // Sequencer: accept, compare, update.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  if (upd_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Row of cells; each takes the entry of its right neighbour on a shift.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] next_entry;
    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry[g+1];
    end
    vst_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .value_i      (val_q),
      .next_entry_i (next_entry),
      .entry_o      (entry[g]),
      .match_o      (match[g])
    );
  end

  vst_match_enc #(
    .CAPACITY (CAPACITY)
  ) u_enc (
    .match_i (match),
    .found_o (hit),
    .slot_o  (slot)
  );

  // Decide the update and the status from the compare result.
  always_comb begin
    do_add    = 1'b0;
    do_remove = 1'b0;
    status_d  = ST_DONE;
    count_d   = count_q;
    unique case (cmd_q)
      CMD_ADD: begin
        if (hit) begin
          status_d = ST_NO_CHANGE;
        end else if (count_q == CntW'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          do_add  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!hit) begin
          status_d = ST_NO_CHANGE;
        end else begin
          do_remove = 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  // Per-cell control: appends land at the fill position, removals shift
  // every live cell from the hit slot onwards but the last live one.
  always_comb begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      ctrl[i].cmp_en = (state_q == S_CMP);
      ctrl[i].live   = CntW'(i) < count_q;
      ctrl[i].load   = upd_fire && do_add && (CntW'(i) == count_q);
      ctrl[i].shift  = upd_fire && do_remove && (IdxW'(i) >= slot) &&
                       (CntW'(i + 1) < count_q);
    end
  end

  // Output register; the count is reported modulo the field width.
  assign count_ext   = {{CountWidth{1'b0}}, count_d};
  assign out_valid_d = upd_fire ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      found_q     <= hit;
      status_q    <= status_d;
      count_out_q <= count_ext[CountWidth-1:0];
      empty_q     <= (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (upd_fire) begin
        count_q <= count_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign status_o    = status_q;
  assign count_o     = count_out_q;
  assign empty_res_o = empty_q;

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count exceeds capacity");

  // Stored values are distinct, so no more than one cell matches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(match))
    else $error("more than one cell matched");

  // An accepted append grows the table by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && do_add) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not grow the count");

  // A successful removal shrinks the table by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && do_remove) |=> (count_q == $past(count_q) - 1'b1))
    else $error("removal did not shrink the count");

endmodule

// File: dv/value_set_table_top_tb.sv
// Self-checking testbench for value_set_table_top: add, remove and query commands
// are predicted against a queue-based copy of the set and checked on every result.
// Depends on vst_pkg and the value_set_table_top RTL.
module value_set_table_top_tb import vst_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity   = DefaultCapacity;
  localparam logic [CmdWidth-1:0] CmdUnused = 2'd3;
  localparam int unsigned PoolSize   = 24;
  localparam int unsigned HoldCycles = 60;

  // One predicted result, as the output channel should carry it.
  typedef struct packed {
    logic                   found;
    status_e                status;
    logic [CountWidth-1:0]  count;
    logic                   empty;
  } set_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [CmdWidth-1:0]    command_i;
  logic [InValWidth-1:0]  value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   found_o;
  logic [StatusWidth-1:0] status_o;
  logic [CountWidth-1:0]  count_o;
  logic                   empty_res_o;

  // Predictor state: the live entries in insertion order.
  logic [InValWidth-1:0] held_values[$];
  set_result_t           pending_results[$];
  logic [InValWidth-1:0] value_pool[PoolSize];

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned items_sent     = 0;
  int unsigned full_rejects   = 0;
  int unsigned peak_fill      = 0;

  // Idling controls shared between the test tasks and the driver processes.
  bit tx_gaps_en  = 1'b1;
  bit rx_stall_en = 1'b1;
  int rx_hold_len = 0;

  value_set_table_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Guard against a hung run.
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Apply one command to the predicted set and return the result it should give.
  function automatic set_result_t apply_set_command(logic [CmdWidth-1:0] cmd,
                                                    logic [InValWidth-1:0] val);
    set_result_t res;
    int slot;
    slot = -1;
    foreach (held_values[i]) begin
      if (slot < 0 && held_values[i] == val) slot = i;
    end
    res.found  = (slot >= 0);
    res.status = ST_DONE;
    case (cmd)
      CMD_ADD: begin
        if (res.found) begin
          res.status = ST_NO_CHANGE;
        end else if (held_values.size() >= Capacity) begin
          res.status = ST_FULL;
          full_rejects++;
        end else begin
          held_values.insert(held_values.size(), val);
        end
      end
      CMD_REMOVE: begin
        if (!res.found) res.status = ST_NO_CHANGE;
        else held_values.delete(slot);
      end
      // Query and the unused code leave the set alone.
      default: ;
    endcase
    res.count = CountWidth'(held_values.size());
    res.empty = (held_values.size() == 0);
    if (held_values.size() > peak_fill) peak_fill = held_values.size();
    return res;
  endfunction

  // Offer one item, optionally after a random gap, and record its prediction
  // once the transfer has taken place.
  task automatic send_command(input logic [CmdWidth-1:0] cmd,
                              input logic [InValWidth-1:0] val);
    set_result_t pred;
    if (tx_gaps_en) begin
      while ($urandom_range(99) < 30) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_set_command(cmd, val);
    pending_results.insert(pending_results.size(), pred);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Draw a command, weighted towards growing or shrinking the set.
  function automatic logic [CmdWidth-1:0] pick_command(int unsigned add_pct,
                                                       int unsigned remove_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < add_pct) return CMD_ADD;
    if (roll < add_pct + remove_pct) return CMD_REMOVE;
    if (roll < 95) return CMD_QUERY;
    return CmdUnused;
  endfunction

  // Mostly values that may be in the set, sometimes a fresh random word.
  function automatic logic [InValWidth-1:0] pick_value();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(PoolSize - 1)];
    return $urandom;
  endfunction

  // Empty-table cases, extreme values, filling to capacity, rejection when
  // full and removal at the front, middle and back of the table.
  task automatic test_directed_edges();
    send_command(CMD_QUERY, 32'h0000_0000);
    send_command(CMD_REMOVE, 32'hFFFF_FFFF);
    send_command(CMD_ADD, 32'h0000_0000);
    send_command(CMD_ADD, 32'hFFFF_FFFF);
    send_command(CMD_ADD, 32'h0000_0000);
    send_command(CmdUnused, 32'hFFFF_FFFF);
    for (int i = 0; i < Capacity - 2; i++) begin
      send_command(CMD_ADD, 32'h8000_0000 >> i);
    end
    send_command(CMD_ADD, 32'h1234_5678);
    send_command(CMD_ADD, 32'h0000_0000);
    send_command(CMD_REMOVE, 32'h8000_0000 >> 6);
    send_command(CMD_REMOVE, 32'h0000_0000);
    send_command(CMD_REMOVE, 32'h8000_0000 >> (Capacity - 3));
    send_command(CMD_QUERY, 32'h1234_5678);
    send_command(CMD_REMOVE, 32'h1234_5678);
    wait_for_results();
  endtask

  // Random phases that alternately grow, churn and shrink the set. The pool
  // keeps the current members so that hits stay frequent.
  task automatic test_random_mix();
    int unsigned add_pct;
    int unsigned remove_pct;
    for (int phase = 0; phase < 6; phase++) begin
      foreach (value_pool[i]) begin
        value_pool[i] = (i < held_values.size()) ? held_values[i] : $urandom;
      end
      case (phase % 3)
        0: begin add_pct = 60; remove_pct = 20; end
        1: begin add_pct = 40; remove_pct = 35; end
        default: begin add_pct = 20; remove_pct = 60; end
      endcase
      // One long stretch with no idling on either side.
      tx_gaps_en  = (phase != 2);
      rx_stall_en = (phase != 2);
      for (int n = 0; n < 100; n++) begin
        send_command(pick_command(add_pct, remove_pct), pick_value());
      end
    end
    tx_gaps_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the block fills and stalls its input.
  task automatic test_backpressure();
    tx_gaps_en  = 1'b0;
    rx_hold_len = HoldCycles;
    for (int n = 0; n < 30; n++) send_command(pick_command(40, 30), pick_value());
    tx_gaps_en = 1'b1;
  endtask

  // The sender pauses until everything is back, then resumes.
  task automatic test_drain_pause();
    for (int n = 0; n < 10; n++) send_command(pick_command(40, 30), pick_value());
    wait_for_results();
    for (int n = 0; n < 10; n++) send_command(pick_command(40, 30), pick_value());
    wait_for_results();
  endtask

  // Result-side ready: random stalls, a counted hold-off on request, or
  // always ready.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_len--;
      end else if (rx_stall_en) begin
        out_ready_i <= ($urandom_range(99) >= 30);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    set_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: found %0d status %0d count %0d empty %0d",
               found_o, status_o, count_o, empty_res_o);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (found_o !== exp_res.found) begin
          $error("found: expected %0d, actual %0d", exp_res.found, found_o);
          mismatch_count++;
        end
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status_o);
          mismatch_count++;
        end
        if (count_o !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, count_o);
          mismatch_count++;
        end
        if (empty_res_o !== exp_res.empty) begin
          $error("empty_res: expected %0d, actual %0d", exp_res.empty, empty_res_o);
          mismatch_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    command_i  <= CMD_QUERY;
    value_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_random_mix();
    test_backpressure();
    test_drain_pause();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d commands and %0d results; peak fill %0d of %0d,",
             items_sent, results_seen, peak_fill, Capacity);
    $display("with %0d adds rejected on a full table.", full_rejects);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
